// ===== hdl/tjaik_pkg.sv =====
// Shared types and constants for the three-joint arm inverse kinematics block.
// Holds the CORDIC angle table, the angle format and the register indexes.
// No dependencies.
package tjaik_pkg;

   // Angles inside the datapath carry 30 fractional bits.
   localparam int QBITS    = 30;
   localparam int ANG_W    = 34;
   // Working width of the CORDIC x and y words.
   localparam int CW       = 44;
   // Operands are normalized until one magnitude reaches 2**NORM_EXP.
   localparam int NORM_EXP = 40;
   // Number of doubling cells in the normalizer.
   localparam int NORM_N   = 7;
   localparam int ATAN_N   = 24;

   typedef logic signed [ANG_W-1:0] angle_type;

   localparam angle_type PI_Q30 = 34'sd3373259426;

   localparam angle_type ATAN_TAB [ATAN_N] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
      34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
      34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
      34'sd1024,      34'sd512,       34'sd256,       34'sd128
   };

   typedef enum logic [2:0] {
      CSR_BASE_HEIGHT     = 3'd0,
      CSR_UPPER_LINK      = 3'd1,
      CSR_LOWER_LINK      = 3'd2,
      CSR_SHOULDER_OFFSET = 3'd3,
      CSR_ELBOW_SAG       = 3'd4
   } csr_index_type;

   // Saturation and sign of one law-of-cosines ratio.
   typedef struct packed {
      logic sat;
      logic neg;
   } cos_flags_type;

endpackage

// ===== hdl/tjaik_delay.sv =====
// Row of registers that carries a side value alongside the arithmetic cells.
// Advances only when the pipeline enable is high. Depends on nothing.
module tjaik_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] sr_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= d;
         for (int k = 1; k < DEPTH; k++) begin
            sr_ff[k] <= sr_ff[k-1];
         end
      end
   end

   assign q = sr_ff[DEPTH-1];

endmodule

// ===== hdl/tjaik_sqrt.sv =====
// Pipelined integer square root rounded to nearest, one result bit per cell.
// Depends on nothing.
module tjaik_sqrt #(
   parameter int IN_W = 32
) (
   input  logic              clock,
   input  logic              en,
   input  logic [IN_W-1:0]   val,
   output logic [IN_W/2:0]   root
);

   localparam int N  = IN_W / 2;
   localparam int RW = N + 3;

   logic [IN_W-1:0] v_ff   [N];
   logic [RW-1:0]   rem_ff [N];
   logic [N-1:0]    rt_ff  [N];
   logic [N:0]      root_ff;

   for (genvar k = 0; k < N; k++) begin : g_cell
      logic [IN_W-1:0] v_cur;
      logic [RW-1:0]   rem_cur;
      logic [N-1:0]    rt_cur;
      logic [RW-1:0]   acc;
      logic [RW-1:0]   trial;
      logic [RW-1:0]   rem_in;
      logic [N-1:0]    rt_in;

      if (k == 0) begin : g_first
         assign v_cur   = val;
         assign rem_cur = '0;
         assign rt_cur  = '0;
      end else begin : g_next
         assign v_cur   = v_ff[k-1];
         assign rem_cur = rem_ff[k-1];
         assign rt_cur  = rt_ff[k-1];
      end

      always_comb begin
         acc   = {rem_cur[N:0], v_cur[IN_W-1:IN_W-2]};
         trial = RW'({rt_cur, 2'b01});
         if (acc >= trial) begin
            rem_in = acc - trial;
            rt_in  = {rt_cur[N-2:0], 1'b1};
         end else begin
            rem_in = acc;
            rt_in  = {rt_cur[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k]   <= v_cur << 2;
            rem_ff[k] <= rem_in;
            rt_ff[k]  <= rt_in;
         end
      end
   end

   // Round up when the remainder exceeds the floor root.
   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= (N+1)'(rt_ff[N-1]) + (N+1)'(rem_ff[N-1] > RW'(rt_ff[N-1]));
      end
   end

   assign root = root_ff;

endmodule

// ===== hdl/tjaik_div.sv =====
// Pipelined restoring divider for a ratio below one, rounded to nearest.
// One quotient bit per cell. Depends on nothing.
module tjaik_div #(
   parameter int NW = 34,
   parameter int QB = 30
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] an,
   input  logic [NW-1:0] ad,
   output logic [QB:0]   q
);

   logic [NW:0]   rem_ff [QB];
   logic [NW-1:0] d_ff   [QB];
   logic [QB-1:0] q_ff   [QB];
   logic [QB:0]   qr_ff;
   logic [NW:0]   rsum;

   for (genvar k = 0; k < QB; k++) begin : g_cell
      logic [NW:0]   rem_cur;
      logic [NW-1:0] d_cur;
      logic [QB-1:0] q_cur;
      logic [NW:0]   sh;
      logic          ge;

      if (k == 0) begin : g_first
         assign rem_cur = (NW+1)'(an);
         assign d_cur   = ad;
         assign q_cur   = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign d_cur   = d_ff[k-1];
         assign q_cur   = q_ff[k-1];
      end

      always_comb begin
         sh = {rem_cur[NW-1:0], 1'b0};
         ge = sh >= (NW+1)'(d_cur);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? sh - (NW+1)'(d_cur) : sh;
            d_ff[k]   <= d_cur;
            q_ff[k]   <= {q_cur[QB-2:0], ge};
         end
      end
   end

   // Adding half the divisor before dividing is the same as this carry.
   assign rsum = rem_ff[QB-1] + (NW+1)'(d_ff[QB-1] >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         qr_ff <= (QB+1)'(q_ff[QB-1]) + (QB+1)'(rsum >= (NW+1)'(d_ff[QB-1]));
      end
   end

   assign q = qr_ff;

endmodule

// ===== hdl/tjaik_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) with 30 fractional bits.
// A half-plane fold, seven normalizing cells, then STAGES rotation cells.
// Uses tjaik_pkg.
module tjaik_cordic #(
   parameter int IN_W   = 16,
   parameter int STAGES = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [IN_W-1:0]   x,
   input  logic signed [IN_W-1:0]   y,
   output tjaik_pkg::angle_type     ang
);
   import tjaik_pkg::*;

   localparam int K = 1 + NORM_N + STAGES;

   logic signed [CW-1:0] x_ff [K];
   logic signed [CW-1:0] y_ff [K];
   angle_type            a_ff [K];
   logic                 z_ff [K];
   logic [CW-1:0]        m_ff [NORM_N+1];

   // Fold the left half plane onto the right one.
   logic signed [CW-1:0] xe, ye, xn_in, yn_in;
   logic [CW-1:0]        ax, ay;
   angle_type            a0_in;

   always_comb begin
      xe = CW'(x);
      ye = CW'(y);
      if (xe < 0) begin
         xn_in = -xe;
         yn_in = -ye;
         a0_in = (ye >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
         xn_in = xe;
         yn_in = ye;
         a0_in = '0;
      end
      ax = xn_in;
      ay = yn_in[CW-1] ? -yn_in : yn_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= xn_in;
         y_ff[0] <= yn_in;
         a_ff[0] <= a0_in;
         z_ff[0] <= (xe == 0) && (ye == 0);
         m_ff[0] <= (ax > ay) ? ax : ay;
      end
   end

   // Greedy doubling: shift by 32, 16, ... 1 while the top stays below the
   // limit, then one more doubling takes the larger magnitude over it.
   for (genvar j = 0; j < NORM_N; j++) begin : g_norm
      localparam int SH  = (j < NORM_N - 1) ? (1 << (NORM_N - 2 - j)) : 1;
      localparam int LIM = (j < NORM_N - 1) ? (NORM_EXP - SH) : NORM_EXP;
      logic grow;

      assign grow = (m_ff[j] >> LIM) == '0;

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[j+1] <= grow ? (x_ff[j] <<< SH) : x_ff[j];
            y_ff[j+1] <= grow ? (y_ff[j] <<< SH) : y_ff[j];
            m_ff[j+1] <= grow ? (m_ff[j] << SH) : m_ff[j];
            a_ff[j+1] <= a_ff[j];
            z_ff[j+1] <= z_ff[j];
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      localparam int P = 1 + NORM_N + i;
      logic signed [CW-1:0] xs, ys;

      assign xs = x_ff[P-1] >>> i;
      assign ys = y_ff[P-1] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_ff[P-1][CW-1]) begin
               x_ff[P] <= x_ff[P-1] + ys;
               y_ff[P] <= y_ff[P-1] - xs;
               a_ff[P] <= a_ff[P-1] + ATAN_TAB[i];
            end else begin
               x_ff[P] <= x_ff[P-1] - ys;
               y_ff[P] <= y_ff[P-1] + xs;
               a_ff[P] <= a_ff[P-1] - ATAN_TAB[i];
            end
            z_ff[P] <= z_ff[P-1];
         end
      end
   end

   assign ang = z_ff[K-1] ? '0 : a_ff[K-1];

endmodule

// ===== hdl/three_joint_arm_inverse_kinematics.sv =====
// Inverse kinematics for a base-yaw, shoulder and elbow arm, fully pipelined.
// Depends on tjaik_pkg, tjaik_delay, tjaik_sqrt, tjaik_div and tjaik_cordic.
//
// The block takes one target word per clock while the pipeline does not hold
// and returns one word of joint angles per target, in order. The pipeline is
// a chain of cells in series: three square-root rows, a divider row and a
// CORDIC row, plus registers for squaring, clamping and rounding. When the
// result side stalls the whole pipeline holds, and the target side is ready
// again in the cycle in which the waiting word is taken. It is not ready
// during reset.
// All lengths and angles are fixed point with FRAC_BITS fractional bits.
module three_joint_arm_inverse_kinematics #(
   parameter int FRAC_BITS     = 13,
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // aim_x [15:0], aim_y [31:16], aim_z [47:32]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // base_angle [15:0], shoulder_angle [31:16], elbow_angle [47:32]
   output logic [47:0] rsp_tdata,
   // reach_limited [0]
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import tjaik_pkg::*;

   localparam int UP_SH  = QBITS - FRAC_BITS;
   localparam int EPS    = ((1 << FRAC_BITS) + 500) / 1000;
   localparam int LIM    = (314 * (1 << FRAC_BITS) + 50) / 100;
   localparam int LIM16  = (LIM > 32767) ? 32767 : LIM;
   localparam int SW     = 40;
   localparam int NW     = 34;
   localparam int CD     = 1 + NORM_N + CORDIC_STAGES;
   localparam int SQR_W  = 32;
   localparam int SQD_W  = 34;
   localparam int SQS_W  = 62;
   localparam int T_R    = 2 + SQR_W / 2 + 1;
   localparam int T_D    = T_R + 2 + SQD_W / 2 + 1;
   localparam int T_LIM  = T_D + 1;
   localparam int T_DIV  = T_LIM + 3;
   localparam int T_Q    = T_DIV + QBITS + 1;
   localparam int T_C    = T_Q + 1;
   localparam int T_V    = T_C + 2;
   localparam int T_S    = T_V + SQS_W / 2 + 1;
   localparam int T_F    = T_S + CD;
   localparam int T_OUT  = T_F + 2;

   localparam logic signed [SW-1:0] HALF      = 1 << (UP_SH - 1);
   localparam logic signed [SW-1:0] ANG_LIM   = LIM;
   localparam logic signed [SW-1:0] WIDE_LIM  = 1 << 30;
   localparam logic signed [SW-1:0] S16_MAX   = 32767;
   localparam logic signed [SW-1:0] S16_MIN   = -32768;

   function automatic logic [15:0] clamp16(input logic signed [SW-1:0] v,
                                           input logic signed [SW-1:0] lim);
      logic signed [SW-1:0] t;
      t = v;
      if (t > lim) begin
         t = lim;
      end else if (t < -lim) begin
         t = -lim;
      end
      if (t > S16_MAX) begin
         t = S16_MAX;
      end else if (t < S16_MIN) begin
         t = S16_MIN;
      end
      return t[15:0];
   endfunction

   // ---------------- configuration registers ----------------
   logic [14:0] bh_ff, l2_ff, l3_ff;
   logic [15:0] off_ff, sag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bh_ff  <= 15'd1499;
         l2_ff  <= 15'd1802;
         l3_ff  <= 15'd1638;
         off_ff <= 16'd2826;
         sag_ff <= 16'd12370;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BASE_HEIGHT:     bh_ff  <= csr_wdata[14:0];
            CSR_UPPER_LINK:      l2_ff  <= csr_wdata[14:0];
            CSR_LOWER_LINK:      l3_ff  <= csr_wdata[14:0];
            CSR_SHOULDER_OFFSET: off_ff <= csr_wdata;
            CSR_ELBOW_SAG:       sag_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic                 en;
   logic [T_OUT:0]       vld_ff;
   logic [T_OUT:0]       vld_in;

   assign en         = !vld_ff[T_OUT] || rsp_tready;
   assign req_tready = en && !reset;
   assign rsp_tvalid = vld_ff[T_OUT];
   assign vld_in     = {vld_ff[T_OUT-1:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- planar reach ----------------
   // The target's x and y are swapped into the planar pair.
   logic signed [15:0] px_ff, py_ff, pz_ff;
   logic signed [31:0] pxe, pye;
   logic [31:0]        pxx_ff, pyy_ff, r2_ff;
   logic signed [16:0] zo1_ff, zo_r;
   logic [16:0]        r;
   angle_type          base_ang, beta_ang;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= req_tdata[31:16];
         py_ff <= req_tdata[15:0];
         pz_ff <= req_tdata[47:32];
      end
   end

   assign pxe = 32'(px_ff);
   assign pye = 32'(py_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         pxx_ff <= pxe * pxe;
         pyy_ff <= pye * pye;
         zo1_ff <= 17'(pz_ff) - $signed({2'b00, bh_ff});
         r2_ff  <= pxx_ff + pyy_ff;
      end
   end

   tjaik_cordic #(.IN_W(16), .STAGES(CORDIC_STAGES)) u_base (
      .clock(clock), .en(en), .x(px_ff), .y(py_ff), .ang(base_ang)
   );

   tjaik_sqrt #(.IN_W(SQR_W)) u_sqrt_r (
      .clock(clock), .en(en), .val(r2_ff), .root(r)
   );

   tjaik_delay #(.W(17), .DEPTH(T_R - 1)) u_dly_zo (
      .clock(clock), .en(en), .d(zo1_ff), .q(zo_r)
   );

   tjaik_cordic #(.IN_W(18), .STAGES(CORDIC_STAGES)) u_beta (
      .clock(clock), .en(en), .x($signed({1'b0, r})), .y(18'(zo_r)),
      .ang(beta_ang)
   );

   // ---------------- full reach and its limit ----------------
   logic signed [33:0] zoe;
   logic [33:0]        rr_ff, zz_ff, d2_ff;
   logic [17:0]        d;
   logic [15:0]        reach;
   logic signed [18:0] dl_ff;
   logic               lim1_ff;

   assign zoe   = 34'(zo_r);
   assign reach = 16'(l2_ff) + 16'(l3_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         rr_ff <= 34'(r) * 34'(r);
         zz_ff <= zoe * zoe;
         d2_ff <= rr_ff + zz_ff;
      end
   end

   tjaik_sqrt #(.IN_W(SQD_W)) u_sqrt_d (
      .clock(clock), .en(en), .val(d2_ff), .root(d)
   );

   // A target out of reach is pulled in just inside the stretched arm.
   always_ff @(posedge clock) begin
      if (en) begin
         if (d > 18'(reach)) begin
            dl_ff   <= $signed(19'(reach)) - 19'(EPS);
            lim1_ff <= 1'b1;
         end else begin
            dl_ff   <= $signed(19'(d));
            lim1_ff <= 1'b0;
         end
      end
   end

   // ---------------- law of cosines ----------------
   logic signed [35:0] dle, l2s;
   logic [33:0]        dd_ff, l22_ff, l33_ff, deng_ff, deng2_ff;
   logic signed [35:0] dena_ff, dena2_ff, numg_ff, numa_ff;
   logic [NW-1:0]      ang_an, ang_ad, ana_an, ana_ad;
   logic [NW-1:0]      ang_an_ff, ang_ad_ff, ana_an_ff, ana_ad_ff;
   logic signed [35:0] abs_g, abs_a, abs_da;
   cos_flags_type      fg_ff, fa_ff, fg_q, fa_q;
   logic               za_ff, za_f;

   assign dle = 36'(dl_ff);
   assign l2s = $signed({21'b0, l2_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         dd_ff    <= 34'(dle * dle);
         l22_ff   <= 34'(l2_ff) * 34'(l2_ff);
         l33_ff   <= 34'(l3_ff) * 34'(l3_ff);
         deng_ff  <= (34'(l2_ff) * 34'(l3_ff)) << 1;
         dena_ff  <= (l2s * dle) <<< 1;
         numg_ff  <= $signed({2'b00, l22_ff}) + $signed({2'b00, l33_ff})
                     - $signed({2'b00, dd_ff});
         numa_ff  <= $signed({2'b00, l22_ff}) + $signed({2'b00, dd_ff})
                     - $signed({2'b00, l33_ff});
         deng2_ff <= deng_ff;
         dena2_ff <= dena_ff;
      end
   end

   always_comb begin
      abs_g  = numg_ff[35] ? -numg_ff : numg_ff;
      abs_a  = numa_ff[35] ? -numa_ff : numa_ff;
      abs_da = dena2_ff[35] ? -dena2_ff : dena2_ff;
      ang_an = abs_g[NW-1:0];
      ang_ad = deng2_ff;
      ana_an = abs_a[NW-1:0];
      ana_ad = abs_da[NW-1:0];
   end

   // A zero gamma denominator saturates with the numerator's sign as well.
   always_ff @(posedge clock) begin
      if (en) begin
         ang_an_ff <= ang_an;
         ang_ad_ff <= ang_ad;
         ana_an_ff <= ana_an;
         ana_ad_ff <= ana_ad;
         fg_ff.sat <= (ang_ad == '0) || (ang_an >= ang_ad);
         fg_ff.neg <= numg_ff[35];
         fa_ff.sat <= ana_an >= ana_ad;
         fa_ff.neg <= (numa_ff[35] != dena2_ff[35]) && (numa_ff != '0);
         za_ff     <= dena2_ff == '0;
      end
   end

   logic [QBITS:0] qg, qa;

   tjaik_div #(.NW(NW), .QB(QBITS)) u_div_g (
      .clock(clock), .en(en), .an(ang_an_ff), .ad(ang_ad_ff), .q(qg)
   );

   tjaik_div #(.NW(NW), .QB(QBITS)) u_div_a (
      .clock(clock), .en(en), .an(ana_an_ff), .ad(ana_ad_ff), .q(qa)
   );

   tjaik_delay #(.W($bits(cos_flags_type)), .DEPTH(T_Q - T_DIV)) u_dly_fg (
      .clock(clock), .en(en), .d(fg_ff), .q(fg_q)
   );

   tjaik_delay #(.W($bits(cos_flags_type)), .DEPTH(T_Q - T_DIV)) u_dly_fa (
      .clock(clock), .en(en), .d(fa_ff), .q(fa_q)
   );

   tjaik_delay #(.W(1), .DEPTH(T_F - T_DIV)) u_dly_za (
      .clock(clock), .en(en), .d(za_ff), .q(za_f)
   );

   // ---------------- acos(c) = atan2(sqrt(1 - c*c), c) ----------------
   logic [QBITS:0]        cmg, cma;
   logic signed [31:0]    cg_ff, ca_ff, cg_s, ca_s;
   logic [QBITS:0]        cmg_abs, cma_abs;
   logic [SQS_W-1:0]      ccg_ff, cca_ff, vg_ff, va_ff;
   logic [31:0]           sg, sa;
   angle_type             gamma_ang, alpha_ang;

   assign cmg = fg_q.sat ? (QBITS+1)'(1) << QBITS : qg;
   assign cma = fa_q.sat ? (QBITS+1)'(1) << QBITS : qa;
   assign cmg_abs = cg_ff[31] ? 31'(-cg_ff) : cg_ff[QBITS:0];
   assign cma_abs = ca_ff[31] ? 31'(-ca_ff) : ca_ff[QBITS:0];

   always_ff @(posedge clock) begin
      if (en) begin
         cg_ff  <= fg_q.neg ? -$signed({1'b0, cmg}) : $signed({1'b0, cmg});
         ca_ff  <= fa_q.neg ? -$signed({1'b0, cma}) : $signed({1'b0, cma});
         ccg_ff <= SQS_W'(cmg_abs) * SQS_W'(cmg_abs);
         cca_ff <= SQS_W'(cma_abs) * SQS_W'(cma_abs);
         vg_ff  <= (SQS_W'(1) << (2 * QBITS)) - ccg_ff;
         va_ff  <= (SQS_W'(1) << (2 * QBITS)) - cca_ff;
      end
   end

   tjaik_sqrt #(.IN_W(SQS_W)) u_sqrt_g (
      .clock(clock), .en(en), .val(vg_ff), .root(sg)
   );

   tjaik_sqrt #(.IN_W(SQS_W)) u_sqrt_a (
      .clock(clock), .en(en), .val(va_ff), .root(sa)
   );

   tjaik_delay #(.W(32), .DEPTH(T_S - T_C)) u_dly_cg (
      .clock(clock), .en(en), .d(cg_ff), .q(cg_s)
   );

   tjaik_delay #(.W(32), .DEPTH(T_S - T_C)) u_dly_ca (
      .clock(clock), .en(en), .d(ca_ff), .q(ca_s)
   );

   tjaik_cordic #(.IN_W(33), .STAGES(CORDIC_STAGES)) u_gamma (
      .clock(clock), .en(en), .x(33'(cg_s)), .y($signed({1'b0, sg})),
      .ang(gamma_ang)
   );

   tjaik_cordic #(.IN_W(33), .STAGES(CORDIC_STAGES)) u_alpha (
      .clock(clock), .en(en), .x(33'(ca_s)), .y($signed({1'b0, sa})),
      .ang(alpha_ang)
   );

   // ---------------- joint angles ----------------
   angle_type            base_f, beta_f;
   logic                 lim_f;
   logic signed [SW-1:0] s2, s3;
   logic signed [SW-1:0] fb_ff, f2_ff, f3_ff;
   logic                 lim2_ff;
   logic [15:0]          ob_ff, os_ff, oe_ff;
   logic                 ol_ff;

   tjaik_delay #(.W(ANG_W), .DEPTH(T_F - CD)) u_dly_base (
      .clock(clock), .en(en), .d(base_ang), .q(base_f)
   );

   tjaik_delay #(.W(ANG_W), .DEPTH(T_F - T_R - CD)) u_dly_beta (
      .clock(clock), .en(en), .d(beta_ang), .q(beta_f)
   );

   tjaik_delay #(.W(1), .DEPTH(T_F - T_LIM)) u_dly_lim (
      .clock(clock), .en(en), .d(lim1_ff), .q(lim_f)
   );

   always_comb begin
      s2 = SW'(beta_f) + (za_f ? '0 : SW'(alpha_ang))
           - (SW'($signed(off_ff)) <<< UP_SH);
      s3 = (SW'($signed(sag_ff)) <<< UP_SH) - SW'(gamma_ang);
   end

   // Angles are rounded half up from 30 fractional bits.
   always_ff @(posedge clock) begin
      if (en) begin
         fb_ff   <= (SW'(base_f) + HALF) >>> UP_SH;
         f2_ff   <= (s2 + HALF) >>> UP_SH;
         f3_ff   <= (s3 + HALF) >>> UP_SH;
         lim2_ff <= lim_f;
         ob_ff   <= clamp16(fb_ff, WIDE_LIM);
         os_ff   <= clamp16(f2_ff, ANG_LIM);
         oe_ff   <= clamp16(f3_ff, ANG_LIM);
         ol_ff   <= lim2_ff;
      end
   end

   assign rsp_tdata = {oe_ff, os_ff, ob_ff};
   assign rsp_tuser = ol_ff;

   // ---------------- checks ----------------
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   a_joint_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[31:16]) <= LIM16)
                  && ($signed(rsp_tdata[31:16]) >= -LIM16)
                  && ($signed(rsp_tdata[47:32]) <= LIM16)
                  && ($signed(rsp_tdata[47:32]) >= -LIM16))
      else $error("joint angle outside its clamp");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   a_take_word : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted word not tracked");

endmodule
